// ===== sv/sgws_pkg.sv =====
// Shared types and constants of the Savitzky-Golay window smoother.
// No dependencies; every other file of the block except sgws_queue imports this package.
`default_nettype none

package sgws_pkg;

    localparam int VAL_W     = 24;
    localparam int TAG_W     = 32;
    localparam int COEF_W    = 18;
    localparam int NUM_COEF  = 7;
    localparam int CFG_IDX_W = 3;
    localparam int FCNT_W    = 3;
    localparam int SLOT_W    = 2;
    localparam int FRAC_W    = 16;

    // 25-bit signed sample times 18-bit weight, and a sum of up to seven of them.
    localparam int PROD_W = VAL_W + 1 + COEF_W;
    localparam int ACC_W  = PROD_W + 3;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [FCNT_W-1:0]    FCNT_MAX      = '1;
    localparam logic [VAL_W-1:0]     VAL_MAX       = '1;
    localparam logic [ACC_W-1:0]     ROUND_HALF    = ACC_W'(1) << (FRAC_W - 1);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST = 3'd6;

    localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
        -18'sd6242, 18'sd9362, 18'sd18725, 18'sd21845, 18'sd18725, 18'sd9362, -18'sd6242
    };

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [COEF_W-1:0]    data;
    } t_cfg_wr;

    // Which slots of a queue entry turn into results: slot 0 is the sample
    // RIGHT_TAPS back from the newest, the highest slot is the newest.
    typedef struct packed {
        logic [SLOT_W-1:0] first;
        logic [SLOT_W-1:0] last_slot;
        logic              is_end;
    } t_ent_meta;

    localparam int META_W = $bits(t_ent_meta);

endpackage

`default_nettype wire

// ===== sv/sgws_in_if.sv =====
// Input sample channel: valid/ready handshake with sample, tag and frame end.
// Depends on sgws_pkg for field widths.
`default_nettype none

interface sgws_in_if;
    import sgws_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] sample_value;
    logic [TAG_W-1:0] position_tag;
    logic             frame_end;

    modport source (output valid, output sample_value, output position_tag,
                    output frame_end, input ready);
    modport sink   (input valid, input sample_value, input position_tag,
                    input frame_end, output ready);
endinterface

`default_nettype wire

// ===== sv/sgws_out_if.sv =====
// Result channel: valid/ready handshake with smoothed value, tag and last flag.
// Depends on sgws_pkg for field widths.
`default_nettype none

interface sgws_out_if;
    import sgws_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] smoothed_value;
    logic [TAG_W-1:0] tag_out;
    logic             last_out;

    modport source (output valid, output smoothed_value, output tag_out,
                    output last_out, input ready);
    modport sink   (input valid, input smoothed_value, input tag_out,
                    input last_out, output ready);
endinterface

`default_nettype wire

// ===== sv/sgws_queue.sv =====
// Small register FIFO between the front pipeline and the result sequencer.
// Depends on nothing but its parameters.
`default_nettype none

module sgws_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty,
    output logic                  o_full
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
endmodule

`default_nettype wire

// ===== sv/sgws_front.sv =====
// Front pipeline: accepts samples, keeps the window and frame count, classifies
// each sample and computes the weighted sum. Depends on sgws_pkg and sgws_in_if.
`default_nettype none

module sgws_front #(
    parameter int LEFT_TAPS  = 3,
    parameter int RIGHT_TAPS = 3
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sgws_pkg::t_cfg_wr i_cfg,
    sgws_in_if.sink              i_in,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output logic [sgws_pkg::META_W + (RIGHT_TAPS + 1) * (sgws_pkg::VAL_W + sgws_pkg::TAG_W) - 1:0]
                                 o_data
);
    import sgws_pkg::*;

    localparam int W  = LEFT_TAPS + RIGHT_TAPS + 1;
    localparam int NS = RIGHT_TAPS + 1;

    logic signed [COEF_W-1:0] r_coef [NUM_COEF];
    logic [VAL_W-1:0]  r_val_win [W];
    logic [TAG_W-1:0]  r_tag_win [W];
    logic [FCNT_W-1:0] r_fcnt;

    logic      r1_valid, r2_valid, r3_valid;
    t_ent_meta r1_meta, r2_meta, r3_meta;
    logic      r1_smooth, r2_smooth, r3_smooth;

    logic signed [PROD_W-1:0] r2_prod [W];
    logic [VAL_W-1:0]         r2_val [NS], r3_val [NS];
    logic [TAG_W-1:0]         r2_tag [NS], r3_tag [NS];
    logic signed [ACC_W-1:0]  r3_acc;

    logic                     en, accept;
    t_ent_meta                n1_meta;
    logic                     n1_has;
    logic signed [PROD_W-1:0] n2_prod [W];
    logic signed [ACC_W-1:0]  n3_acc;
    logic [VAL_W-1:0]         center;

    // The whole pipeline moves together and stops only when its last stage
    // holds an entry that the queue cannot take.
    assign en         = !(r3_valid && i_q_full);
    assign accept     = i_in.valid && en;
    assign i_in.ready = en;

    always_comb begin
        n1_meta.is_end    = i_in.frame_end;
        n1_meta.last_slot = i_in.frame_end ? SLOT_W'(RIGHT_TAPS) : '0;
        n1_meta.first     = '0;
        if (i_in.frame_end && (r_fcnt < FCNT_W'(RIGHT_TAPS))) begin
            n1_meta.first = SLOT_W'(RIGHT_TAPS) - SLOT_W'(r_fcnt);
        end
        n1_has = i_in.frame_end || (r_fcnt >= FCNT_W'(RIGHT_TAPS));
    end

    always_comb begin
        logic signed [VAL_W:0] vx;
        for (int j = 0; j < W; j++) begin
            vx         = signed'({1'b0, r_val_win[j]});
            n2_prod[j] = vx * r_coef[j];
        end
    end

    always_comb begin
        n3_acc = '0;
        for (int j = 0; j < W; j++) begin
            n3_acc = n3_acc + ACC_W'(r2_prod[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef   <= COEF_RESET;
            r_fcnt   <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            for (int i = 0; i < W; i++) begin
                r_val_win[i] <= '0;
                r_tag_win[i] <= '0;
            end
        end else begin
            if (i_cfg.we && (i_cfg.idx <= CFG_COEF_LAST)) begin
                r_coef[i_cfg.idx] <= signed'(i_cfg.data);
            end
            if (en) begin
                r1_valid <= accept && n1_has;
                r2_valid <= r1_valid;
                r3_valid <= r2_valid;
            end
            if (accept) begin
                for (int i = 0; i < W - 1; i++) begin
                    r_val_win[i] <= r_val_win[i + 1];
                    r_tag_win[i] <= r_tag_win[i + 1];
                end
                r_val_win[W - 1] <= i_in.sample_value;
                r_tag_win[W - 1] <= i_in.position_tag;
                if (i_in.frame_end) begin
                    r_fcnt <= '0;
                end else if (r_fcnt != FCNT_MAX) begin
                    r_fcnt <= r_fcnt + FCNT_W'(1);
                end
            end
        end
    end

    // Stage 2 reads the window while stage 1 holds the item that shifted it in.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_meta   <= n1_meta;
            r1_smooth <= (r_fcnt >= FCNT_W'(LEFT_TAPS + RIGHT_TAPS));
            r2_meta   <= r1_meta;
            r2_smooth <= r1_smooth;
            r2_prod   <= n2_prod;
            for (int s = 0; s < NS; s++) begin
                r2_val[s] <= r_val_win[LEFT_TAPS + s];
                r2_tag[s] <= r_tag_win[LEFT_TAPS + s];
            end
            r3_meta   <= r2_meta;
            r3_smooth <= r2_smooth;
            r3_acc    <= n3_acc;
            r3_val    <= r2_val;
            r3_tag    <= r2_tag;
        end
    end

    function automatic logic [VAL_W-1:0] round_clamp(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-1:0]        rnd;
        logic [ACC_W-FRAC_W-1:0] q;
        rnd = unsigned'(acc) + ROUND_HALF;
        q   = rnd[ACC_W-1:FRAC_W];
        if (acc[ACC_W-1]) begin
            return '0;
        end else if (q > (ACC_W - FRAC_W)'(VAL_MAX)) begin
            return VAL_MAX;
        end else begin
            return q[VAL_W-1:0];
        end
    endfunction

    assign center = r3_smooth ? round_clamp(r3_acc) : r3_val[0];

    always_comb begin
        o_data[$bits(o_data)-1 -: META_W] = r3_meta;
        for (int s = 0; s < NS; s++) begin
            o_data[NS * TAG_W + s * VAL_W +: VAL_W] = (s == 0) ? center : r3_val[s];
            o_data[s * TAG_W +: TAG_W]              = r3_tag[s];
        end
    end

    assign o_push = en && r3_valid;
endmodule

`default_nettype wire

// ===== sv/sgws_back.sv =====
// Result sequencer: walks the slots of the queue head, one result per beat,
// into a registered output stage. Depends on sgws_pkg and sgws_out_if.
`default_nettype none

module sgws_back #(
    parameter int RIGHT_TAPS = 3
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic [sgws_pkg::META_W + (RIGHT_TAPS + 1) * (sgws_pkg::VAL_W + sgws_pkg::TAG_W) - 1:0]
                       i_data,
    input  wire logic  i_empty,
    output logic       o_pop,
    sgws_out_if.source o_out
);
    import sgws_pkg::*;

    localparam int NS = RIGHT_TAPS + 1;

    t_ent_meta         head;
    logic [SLOT_W-1:0] r_slot, cur_slot;
    logic              r_started;
    logic              r_out_valid, r_out_last;
    logic [VAL_W-1:0]  r_out_val;
    logic [TAG_W-1:0]  r_out_tag;
    logic              load, emit, at_last;

    assign head     = i_data[$bits(i_data)-1 -: META_W];
    assign cur_slot = r_started ? r_slot : head.first;
    assign at_last  = (cur_slot == head.last_slot);
    assign load     = !r_out_valid || o_out.ready;
    assign emit     = load && !i_empty;
    assign o_pop    = emit && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
            r_slot      <= '0;
        end else begin
            if (load) begin
                r_out_valid <= !i_empty;
            end
            if (emit) begin
                r_started <= !at_last;
                r_slot    <= cur_slot + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_val  <= i_data[NS * TAG_W + cur_slot * VAL_W +: VAL_W];
            r_out_tag  <= i_data[cur_slot * TAG_W +: TAG_W];
            r_out_last <= head.is_end && at_last;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.smoothed_value = r_out_val;
    assign o_out.tag_out        = r_out_tag;
    assign o_out.last_out       = r_out_last;
endmodule

`default_nettype wire

// ===== sv/savitzky_golay_window_smoother.sv =====
// Top level of the Savitzky-Golay window smoother: front pipeline, entry queue
// and result sequencer. Depends on sgws_pkg, sgws_in_if, sgws_out_if and submodules.
//
//   channel   direction  beat contents
//   i_in      in         sample_value, position_tag, frame_end
//   o_out     out        smoothed_value, tag_out, last_out
//   i_cfg_*   in         coefficient write: index 0..6, 18-bit signed Q1.16
//
// One sample is accepted per cycle unless the input stalls, and one result leaves
// per cycle while o_out is ready. A frame's last sample yields up to RIGHT_TAPS + 1
// results, sent on consecutive beats. A sample passes the window, product and sum
// registers and the queue to the output register. Synchronous reset restores
// the default coefficients and empties pipeline, queue and window.
// Input stalls only when the queue is full and the last front stage is occupied.
`default_nettype none

module savitzky_golay_window_smoother #(
    parameter int LEFT_TAPS  = 3,
    parameter int RIGHT_TAPS = 3
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [sgws_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [sgws_pkg::COEF_W-1:0]       i_cfg_data,
    sgws_in_if.sink                                i_in,
    sgws_out_if.source                             o_out
);
    import sgws_pkg::*;

    localparam int ENT_W = META_W + (RIGHT_TAPS + 1) * (VAL_W + TAG_W);

    t_cfg_wr          cfg;
    logic             push, pop, q_empty, q_full;
    logic [ENT_W-1:0] push_data, head_data;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    sgws_front #(
        .LEFT_TAPS  (LEFT_TAPS),
        .RIGHT_TAPS (RIGHT_TAPS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_data   (push_data)
    );

    sgws_queue #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (head_data),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    sgws_back #(
        .RIGHT_TAPS (RIGHT_TAPS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (head_data),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule

`default_nettype wire
